### rtl/core/blls_pkg.sv
// Shared types and constants for the Bernoulli log-likelihood and score block.
// Used by every module under rtl/core; depends on nothing.
package blls_pkg;

    typedef enum logic {
        KIND_COEF = 1'b0,
        KIND_FEAT = 1'b1
    } t_kind;

    typedef struct packed {
        logic               action;
        logic [3:0]         coef_index;
        logic signed [15:0] value;
        logic signed [15:0] label;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         feature_index;
        logic signed [31:0] log_likelihood;
        logic signed [47:0] score;
        logic               score_saturated;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         slot;
        logic signed [15:0] value;
        logic signed [15:0] label;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_out;

    localparam logic signed [31:0] LN2_Q30   = 32'sd744261118;
    localparam logic signed [29:0] LOG2_BIAS = 30'sd402653184;
    localparam logic signed [61:0] LN_HALF   = 62'sd536870912;
    localparam logic signed [40:0] ONE_Q24   = 41'sd16777216;
    localparam logic signed [17:0] ONE_Q14   = 18'sd16384;
    localparam logic signed [51:0] LL_HALF   = 52'sd8192;
    localparam logic signed [31:0] LL_MAX    = 32'sh7FFFFFFF;
    localparam logic signed [31:0] LL_MIN    = 32'sh80000000;
    localparam logic signed [56:0] SCORE_MAX = 57'sd140737488355327;
    localparam logic signed [56:0] SCORE_MIN = -57'sd140737488355328;

endpackage

### rtl/core/bernoulli_linear_loglik_score_top.sv
// Last feature: two log passes if the sum is in range, then for each result two 54-step
// divisions on the shared one-bit-per-cycle divider, skipped when a denominator is zero.
// Back end: one sample at a time; the two-entry queue keeps taking items while it is busy.
// Reset: synchronous, active low; clears coefficients, sum, position, queue; count to 1.
// Depends on blls_pkg, blls_front and blls_back.
module bernoulli_linear_loglik_score_top import blls_pkg::*; #(
    parameter int MAX_FEATURES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data
);

    logic [4:0] r_feature_count;
    t_q_out     q;
    logic       q_pop;
    logic       back_idle;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_feature_count <= i_cfg_data;
        end
    end

    blls_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_pop      (q_pop),
        .o_q        (q)
    );

    blls_back #(.MAX_FEATURES(MAX_FEATURES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_pop       (q_pop),
        .o_idle      (back_idle),
        .i_count     (r_feature_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q.valid) else $error("queue popped while empty");
    a_pop_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> back_idle) else $error("queue popped while back end busy");
    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q.job.kind == KIND_FEAT) |=> !back_idle)
        else $error("feature item did not start work");
`endif

endmodule

### rtl/core/blls_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on blls_pkg.
module blls_front import blls_pkg::*; #(
    parameter int MAX_FEATURES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_pop,
    output t_q_out   o_q
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_keep, w_push;
    t_job       w_job;

    always_comb begin
        w_job.kind  = i_in_item.action ? KIND_FEAT : KIND_COEF;
        w_job.slot  = i_in_item.coef_index;
        w_job.value = i_in_item.value;
        w_job.label = i_in_item.label;
    end

    // drop coefficient writes beyond the table
    assign w_keep     = i_in_item.action || (int'(i_in_item.coef_index) < MAX_FEATURES);
    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall && w_keep;
    assign o_q.valid  = (r_cnt != 2'd0);
    assign o_q.job    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_job;
    end

endmodule

### rtl/core/blls_ln.sv
// Iterative natural log of a Q0.24 fraction: normalize, 24 squaring rounds, scale by ln2.
// Depends on blls_pkg.
module blls_ln import blls_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [23:0]        i_u,
    output logic               o_done,
    output logic signed [31:0] o_ln
);

    typedef enum logic [2:0] {S_IDLE, S_NORM, S_SQ, S_ADJ, S_FIN, S_RND} t_state;

    t_state             r_state;
    logic               r_done;
    logic [23:0]        r_u;
    logic [4:0]         r_e;
    logic [23:0]        r_f;
    logic [30:0]        r_z;
    logic [61:0]        r_sq;
    logic [4:0]         r_k;
    logic signed [61:0] r_prod;
    logic signed [31:0] r_ln;
    logic [31:0]        w_t;
    logic signed [29:0] w_l2;
    logic signed [61:0] w_rnd;

    assign w_t    = r_sq[61:30];
    assign w_l2   = $signed({1'b0, r_e, r_f}) - LOG2_BIAS;
    assign w_rnd  = r_prod + LN_HALF;
    assign o_done = r_done;
    assign o_ln   = r_ln;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_u     <= i_u;
                        r_e     <= 5'd23;
                        r_f     <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_u[23]) begin
                        r_z     <= {r_u, 7'd0};
                        r_k     <= 5'd0;
                        r_state <= S_SQ;
                    end else begin
                        r_u <= {r_u[22:0], 1'b0};
                        r_e <= r_e - 5'd1;
                    end
                end
                S_SQ: begin
                    r_sq    <= r_z * r_z;
                    r_state <= S_ADJ;
                end
                S_ADJ: begin
                    if (w_t[31]) begin
                        r_f[5'd23 - r_k] <= 1'b1;
                        r_z              <= w_t[31:1];
                    end else begin
                        r_z <= w_t[30:0];
                    end
                    r_k     <= r_k + 5'd1;
                    r_state <= (r_k == 5'd23) ? S_FIN : S_SQ;
                end
                S_FIN: begin
                    r_prod  <= w_l2 * LN2_Q30;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_ln    <= 32'(w_rnd >>> 30);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/blls_div.sv
// Radix-2 restoring divider: (num * 2^22) / den, truncating toward zero, one bit per cycle.
// Depends on blls_pkg.
module blls_div import blls_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [40:0] i_den,
    output logic               o_done,
    output logic signed [55:0] o_quo
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} t_state;

    t_state             r_state;
    logic               r_done;
    logic [53:0]        r_dvd;
    logic [40:0]        r_rem;
    logic [40:0]        r_d;
    logic               r_neg;
    logic [5:0]         r_cnt;
    logic signed [55:0] r_quo;
    logic [31:0]        w_mag_n;
    logic [40:0]        w_mag_d;
    logic [41:0]        w_trial;
    logic               w_ge;

    assign w_mag_n = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_mag_d = i_den[40] ? 41'(-i_den) : 41'(i_den);
    assign w_trial = {r_rem, r_dvd[53]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= {w_mag_n, 22'd0};
                        r_d     <= w_mag_d;
                        r_rem   <= '0;
                        r_cnt   <= 6'd0;
                        r_neg   <= i_num[31] ^ i_den[40];
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem   <= w_ge ? 41'(w_trial - {1'b0, r_d}) : w_trial[40:0];
                    r_dvd   <= {r_dvd[52:0], w_ge};
                    r_cnt   <= r_cnt + 6'd1;
                    if (r_cnt == 6'd53) r_state <= S_FIX;
                end
                S_FIX: begin
                    r_quo   <= r_neg ? -$signed({2'b00, r_dvd}) : $signed({2'b00, r_dvd});
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/blls_back.sv
// Back end: coefficient table, multiply-accumulate, log-likelihood and per-feature scores.
// Depends on blls_pkg, blls_ln and blls_div.
module blls_back import blls_pkg::*; #(
    parameter int MAX_FEATURES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_out    i_q,
    output logic      o_pop,
    output logic      o_idle,
    input  logic [4:0] i_count,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW = $clog2(MAX_FEATURES + 1);
    localparam int NW = (PW > 5) ? PW : 5;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_LLCHK, S_LN1, S_LN2, S_LLB, S_LLR,
        S_RD, S_NUM, S_SPC, S_DIV1, S_DIV2, S_EMIT
    } t_state;

    t_state             r_state;
    logic signed [15:0] r_coef [MAX_FEATURES];
    logic signed [15:0] r_fs   [MAX_FEATURES];
    logic signed [39:0] r_sum;
    logic [PW-1:0]      r_pos;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_i;
    logic               r_end;
    logic               r_mac_en;
    logic signed [15:0] r_y;
    logic signed [15:0] r_x;
    logic signed [31:0] r_prod;
    logic signed [31:0] r_l1;
    logic signed [31:0] r_l2;
    logic signed [51:0] r_acc;
    logic signed [31:0] r_ll;
    logic signed [31:0] r_n1;
    logic signed [31:0] r_n2;
    logic signed [55:0] r_q1;
    logic signed [47:0] r_score;
    logic               r_sat;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [NW-1:0]      w_n;
    logic signed [40:0] w_sum41;
    logic signed [40:0] w_d2;
    logic               w_ln_start;
    logic [23:0]        w_ln_u;
    logic               ln_done;
    logic signed [31:0] ln_res;
    logic               w_div_start;
    logic signed [31:0] w_div_num;
    logic signed [40:0] w_div_den;
    logic               div_done;
    logic signed [55:0] div_quo;
    logic signed [51:0] w_llr;
    logic signed [56:0] w_s;
    logic               w_in_range;
    logic               w_emit;
    logic               w_last;

    always_comb begin
        if (i_count == 5'd0)                     w_n = NW'(1);
        else if (int'(i_count) > MAX_FEATURES)  w_n = NW'(MAX_FEATURES);
        else                                     w_n = NW'(i_count);
    end

    assign w_sum41    = 41'(r_sum);
    assign w_d2       = ONE_Q24 - w_sum41;
    assign w_in_range = (r_sum > 40'sd0) && (w_sum41 < ONE_Q24);

    assign w_ln_start = ((r_state == S_LLCHK) && w_in_range) || ((r_state == S_LN1) && ln_done);
    assign w_ln_u     = (r_state == S_LLCHK) ? r_sum[23:0] : w_d2[23:0];

    assign w_div_start = ((r_state == S_SPC) && (r_sum != 40'sd0) && (w_d2 != 41'sd0))
                       || ((r_state == S_DIV1) && div_done);
    assign w_div_num   = (r_state == S_SPC) ? r_n1 : r_n2;
    assign w_div_den   = (r_state == S_SPC) ? w_sum41 : w_d2;

    assign w_llr  = (r_acc + LL_HALF) >>> 14;
    assign w_s    = 57'(r_q1) - 57'(div_quo);
    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_last = ((r_i + NW'(1)) == r_n);

    assign o_pop       = (r_state == S_IDLE) && i_q.valid;
    assign o_idle      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    blls_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ln_start),
        .i_u     (w_ln_u),
        .o_done  (ln_done),
        .o_ln    (ln_res)
    );

    blls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_FEATURES; k++) r_coef[k] <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_emit) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        if (i_q.job.kind == KIND_COEF) begin
                            r_coef[AW'(i_q.job.slot)] <= i_q.job.value;
                        end else begin
                            r_mac_en <= (int'(r_pos) < MAX_FEATURES);
                            if (int'(r_pos) < MAX_FEATURES) begin
                                r_fs[AW'(r_pos)] <= i_q.job.value;
                                r_prod <= r_coef[AW'(r_pos)] * i_q.job.value;
                            end
                            r_pos   <= r_pos + PW'(1);
                            r_y     <= i_q.job.label;
                            r_n     <= w_n;
                            r_end   <= ((NW'(r_pos) + NW'(1)) >= w_n);
                            r_state <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    if (r_mac_en) r_sum <= r_sum + 40'(r_prod);
                    r_state <= r_end ? S_LLCHK : S_IDLE;
                end
                S_LLCHK: begin
                    r_i <= '0;
                    if (r_sum <= 40'sd0) begin
                        if (r_y == 16'sd0)     r_ll <= 32'sd0;
                        else if (r_y > 16'sd0) r_ll <= LL_MIN;
                        else                   r_ll <= LL_MAX;
                        r_state <= S_RD;
                    end else if (!w_in_range) begin
                        r_ll    <= LL_MIN;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_LN1;
                    end
                end
                S_LN1: begin
                    if (ln_done) begin
                        r_l1    <= ln_res;
                        r_state <= S_LN2;
                    end
                end
                S_LN2: begin
                    if (ln_done) begin
                        r_l2    <= ln_res;
                        r_acc   <= 52'(r_y * r_l1);
                        r_state <= S_LLB;
                    end
                end
                S_LLB: begin
                    r_acc   <= r_acc + 52'((ONE_Q14 - 18'(r_y)) * r_l2);
                    r_state <= S_LLR;
                end
                S_LLR: begin
                    if (w_llr > 52'(LL_MAX))      r_ll <= LL_MAX;
                    else if (w_llr < 52'(LL_MIN)) r_ll <= LL_MIN;
                    else                          r_ll <= w_llr[31:0];
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_x     <= r_fs[AW'(r_i)];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_n1    <= 32'(r_y * r_x);
                    r_n2    <= 32'((ONE_Q14 - 18'(r_y)) * r_x);
                    r_state <= S_SPC;
                end
                S_SPC: begin
                    priority if (r_sum == 40'sd0) begin
                        r_sat   <= 1'b1;
                        r_score <= (r_n1 > 32'sd0) ? SCORE_MAX[47:0] :
                                   (r_n1 < 32'sd0) ? SCORE_MIN[47:0] : 48'sd0;
                        r_state <= S_EMIT;
                    end else if (w_d2 == 41'sd0) begin
                        r_sat   <= 1'b1;
                        r_score <= (r_n2 > 32'sd0) ? SCORE_MIN[47:0] :
                                   (r_n2 < 32'sd0) ? SCORE_MAX[47:0] : 48'sd0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_q1    <= div_quo;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        if (w_s > SCORE_MAX) begin
                            r_sat   <= 1'b1;
                            r_score <= SCORE_MAX[47:0];
                        end else if (w_s < SCORE_MIN) begin
                            r_sat   <= 1'b1;
                            r_score <= SCORE_MIN[47:0];
                        end else begin
                            r_sat   <= 1'b0;
                            r_score <= w_s[47:0];
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_valid           <= 1'b1;
                        r_out.feature_index   <= 4'(r_i);
                        r_out.log_likelihood  <= r_ll;
                        r_out.score           <= r_score;
                        r_out.score_saturated <= r_sat;
                        r_out.last            <= w_last;
                        if (w_last) begin
                            r_sum   <= '0;
                            r_pos   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + NW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### dv/bernoulli_linear_loglik_score_top_tb.sv
// Testbench for bernoulli_linear_loglik_score_top: directed and random items against a
// built-in fixed-point predictor, with random idling on the input and result channels.
// Depends on blls_pkg and the RTL of the block.
module bernoulli_linear_loglik_score_top_tb;
    import blls_pkg::*;

    localparam int     NMAX      = 16;
    localparam longint Q24       = 64'sd16777216;
    localparam longint Q14       = 64'sd16384;
    localparam longint LN2_FIX   = 64'sd744261118;
    localparam longint SMAX      = 64'sd140737488355327;
    localparam longint SMIN      = -64'sd140737488355328;
    localparam longint LLMAX     = 64'sd2147483647;
    localparam longint LLMIN     = -64'sd2147483648;
    localparam int     IDLE_TAIL = 24;
    localparam int     WDOG_MAX  = 5000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [4:0] i_cfg_data;

    bernoulli_linear_loglik_score_top #(.MAX_FEATURES(NMAX)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    longint    weights [NMAX];
    longint    sample_x [NMAX];
    longint    lin_pred;
    int        feat_pos;
    logic [4:0] feat_count;

    t_out_item expected_scores [$];
    int        error_count;
    int        items_sent;
    bit        calm;
    int        stall_left;
    int        idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint ln_fixed(longint unsigned u);
        int               e;
        longint unsigned  z;
        longint           f;
        longint           l2;
        e = 23;
        f = 0;
        while (e > 0 && u[e] == 1'b0)
            e--;
        z = u << (30 - e);
        for (int k = 0; k < 24; k++) begin
            z = (z * z) >> 30;
            if (z >= (64'd1 << 31)) begin
                f = f | (64'sd1 << (23 - k));
                z = z >> 1;
            end
        end
        l2 = longint'(e) * Q24 + f - 64'sd24 * Q24;
        return (l2 * LN2_FIX + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint loglik_of(longint lp, longint y);
        longint acc;
        if (lp <= 0)
            return (y == 0) ? 64'sd0 : ((y > 0) ? LLMIN : LLMAX);
        if (lp >= Q24)
            return LLMIN;
        acc = y * ln_fixed(lp) + (Q14 - y) * ln_fixed(Q24 - lp);
        acc = (acc + 64'sd8192) >>> 14;
        if (acc > LLMAX) return LLMAX;
        if (acc < LLMIN) return LLMIN;
        return acc;
    endfunction

    function automatic longint score_of(longint lp, longint y, longint x, output bit sat);
        longint n1;
        longint n2;
        longint d2;
        longint s;
        n1 = y * x;
        n2 = (Q14 - y) * x;
        d2 = Q24 - lp;
        sat = 1'b0;
        if (lp == 0) begin
            sat = 1'b1;
            return (n1 > 0) ? SMAX : ((n1 < 0) ? SMIN : 64'sd0);
        end
        if (d2 == 0) begin
            sat = 1'b1;
            return (n2 > 0) ? SMIN : ((n2 < 0) ? SMAX : 64'sd0);
        end
        s = (n1 * 64'sd4194304) / lp - (n2 * 64'sd4194304) / d2;
        if (s > SMAX) begin sat = 1'b1; return SMAX; end
        if (s < SMIN) begin sat = 1'b1; return SMIN; end
        return s;
    endfunction

    task automatic predict_item(t_in_item it);
        int        n;
        longint    y;
        longint    ll;
        longint    s;
        bit        sat;
        t_out_item r;
        if (t_kind'(it.action) == KIND_COEF) begin
            weights[it.coef_index] = longint'(it.value);
            return;
        end
        n = (feat_count == 0) ? 1 : ((feat_count > NMAX) ? NMAX : int'(feat_count));
        if (feat_pos < NMAX) begin
            sample_x[feat_pos] = longint'(it.value);
            lin_pred += weights[feat_pos] * longint'(it.value);
        end
        feat_pos++;
        if (feat_pos < n)
            return;
        y = longint'(it.label);
        ll = loglik_of(lin_pred, y);
        for (int i = 0; i < n; i++) begin
            s = score_of(lin_pred, y, sample_x[i], sat);
            r.feature_index   = 4'(i);
            r.log_likelihood  = 32'(ll);
            r.score           = 48'(s);
            r.score_saturated = sat;
            r.last            = (i + 1 == n);
            expected_scores.push_back(r);
        end
        lin_pred = 0;
        feat_pos = 0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_item(logic action, logic [3:0] slot, logic [15:0] value,
                             logic [15:0] label);
        t_in_item it;
        it.action     = action;
        it.coef_index = slot;
        it.value      = value;
        it.label      = label;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(it);
        items_sent++;
    endtask

    task automatic send_coef(int slot, longint value);
        send_item(KIND_COEF, 4'(slot), 16'(value), 16'($urandom));
    endtask

    task automatic send_feature(longint value, longint label);
        send_item(KIND_FEAT, 4'($urandom), 16'(value), 16'(label));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_count(int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 5'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        feat_count = 5'(value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_zero_predictor();
        send_feature(4096, 0);
        send_feature(-4096, 8192);
        send_feature(32767, -8192);
        wait_drained();
    endtask

    task automatic test_corner_samples();
        write_count(2);
        send_coef(0, 4096);
        send_coef(1, -32768);
        send_coef(15, 32767);
        send_feature(2048, 0);
        send_feature(0, 16384);
        send_feature(4096, 0);
        send_feature(0, 8192);
        send_feature(32767, 0);
        send_feature(-32768, 32767);
        send_feature(-32768, 0);
        send_feature(32767, -32768);
        send_feature(1, 0);
        send_feature(0, 0);
        wait_drained();
        write_count(0);
        send_feature(4095, 16383);
        wait_drained();
    endtask

    task automatic test_count_change_midsample();
        write_count(4);
        send_feature(1024, 0);
        send_feature(-512, 0);
        wait_drained();
        write_count(2);
        send_feature(777, 12000);
        wait_drained();
    endtask

    task automatic random_sample(int n);
        int bound;
        bound = 4096 / n;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_coef($urandom_range(0, 15), $urandom_range(0, 1) ? $urandom_range(0, bound)
                          : longint'(16'($urandom)));
            send_feature($urandom_range(0, 4) ? $urandom_range(0, bound)
                         : longint'($signed(16'($urandom))),
                         $urandom_range(0, 3) ? $urandom_range(0, 16384)
                         : longint'($signed(16'($urandom))));
        end
    endtask

    task automatic test_random_samples();
        int counts [8] = '{3, 1, 16, 5, 31, 2, 0, 4};
        int phase;
        int n;
        phase = 0;
        while (items_sent < 155) begin
            if (items_sent > 125)
                calm = 1'b1;
            write_count(counts[phase % 8]);
            n = (feat_count == 0) ? 1 : ((feat_count > NMAX) ? NMAX : int'(feat_count));
            for (int s = 0; s < NMAX; s++)
                if (s < n || $urandom_range(0, 3) == 0)
                    send_coef(s, $urandom_range(0, 1) ? $urandom_range(0, 4096 / n)
                              : longint'(16'($urandom)));
            repeat ((n > 8) ? 1 : 3) random_sample(n);
            wait_drained();
            phase++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
        end
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                if (expected_scores.size() == 0) begin
                    report_mismatch("unexpected item index", o_out_item.feature_index, -1);
                end else begin
                    want = expected_scores.pop_front();
                    if (o_out_item.feature_index != want.feature_index)
                        report_mismatch("feature_index", o_out_item.feature_index,
                                        want.feature_index);
                    if (o_out_item.log_likelihood != want.log_likelihood)
                        report_mismatch("log_likelihood", o_out_item.log_likelihood,
                                        want.log_likelihood);
                    if (o_out_item.score != want.score)
                        report_mismatch("score", o_out_item.score, want.score);
                    if (o_out_item.score_saturated != want.score_saturated)
                        report_mismatch("score_saturated", o_out_item.score_saturated,
                                        want.score_saturated);
                    if (o_out_item.last != want.last)
                        report_mismatch("last", o_out_item.last, want.last);
                end
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        error_count = 0;
        items_sent  = 0;
        calm        = 1'b0;
        lin_pred    = 0;
        feat_pos    = 0;
        feat_count  = 5'd1;
        for (int i = 0; i < NMAX; i++) begin
            weights[i]  = 0;
            sample_x[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_predictor();
        test_corner_samples();
        test_count_change_midsample();
        test_random_samples();
        wait_drained();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
